>>> sv/rea_pkg.sv
// ----------------------------------------------------------------------------
// rea_pkg
// Types, constants and codes shared by the rotary encoder shaper files.
// ----------------------------------------------------------------------------
package rea_pkg;

  localparam int NUM_ENCODERS = 2;
  localparam int ENC_AW       = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  localparam int ACCUM_W = 16;
  localparam int STAMP_W = 32;
  localparam int SPEED_W = 4;
  localparam int STEP_W  = 13;
  localparam int V_W     = ACCUM_W + 1;
  localparam int CNT_W   = $clog2(ACCUM_W);
  localparam int PROD_W  = SPEED_W + 7;

  localparam logic [STAMP_W-1:0] FAST_MS        = 32'd50;
  localparam logic [STAMP_W-1:0] SLOW_MS        = 32'd200;
  localparam logic [SPEED_W-1:0] SPEED_MAX      = 4'd10;
  localparam logic [SPEED_W-1:0] LIST_SPEED_MIN = 4'd5;
  localparam logic [SPEED_W-1:0] MULT_MAX       = 4'd10;

  // x / 10 == (x * 6554) >> 16 for every x below 16384
  localparam logic [15:0] RECIP_10    = 16'd6554;
  localparam int          RECIP_SHIFT = 16;

  typedef enum logic [1:0] {
    CFG_ACCEL_ENABLE = 2'd0,
    CFG_ACCEL_FACTOR = 2'd1,
    CFG_DEAD_ZONE    = 2'd2,
    CFG_NOTCH_DIV    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ACT_MOVE  = 1'b0,
    ACT_CLEAR = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    MODE_NAV    = 2'd0,
    MODE_EDIT   = 2'd1,
    MODE_ADJUST = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_ACC,
    S_MUL,
    S_PROD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic               action;
    logic [1:0]         encoder_index;
    logic signed [7:0]  raw_delta;
    logic [1:0]         shaping_mode;
    logic [31:0]        now_ms;
  } rea_in_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_out;
  } rea_out_t;

  typedef struct packed {
    logic signed [ACCUM_W-1:0] accum;
    logic [STAMP_W-1:0]        stamp_ms;
    dir_t                      prev_dir;
    logic [SPEED_W-1:0]        speed;
  } slot_t;

endpackage

>>> sv/rea_in_if.sv
// ----------------------------------------------------------------------------
// rea_in_if
// Valid/ready channel carrying one encoder event or clear request per beat.
// ----------------------------------------------------------------------------
interface rea_in_if import rea_pkg::*; ();
  logic    valid;
  logic    ready;
  rea_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rea_out_if.sv
// ----------------------------------------------------------------------------
// rea_out_if
// Valid/ready channel carrying one shaped step count per beat.
// ----------------------------------------------------------------------------
interface rea_out_if import rea_pkg::*; ();
  logic     valid;
  logic     ready;
  rea_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rotary_encoder_accel_shaper.sv
// ----------------------------------------------------------------------------
// rotary_encoder_accel_shaper
// Per-encoder velocity tracking, dead zone, detent division and step shaping.
// ----------------------------------------------------------------------------
// in_ch carries one beat per event: a movement or a clear for one encoder.
// Every input beat produces exactly one beat on out_ch with the shaped step
// count, zero when nothing is emitted.
// Per-encoder state sits in a small synchronous memory read on the accept
// edge and written back from the update state; one beat is in flight at a time.
// Beats that end without a division (clear, bad index, zero delta, dead zone not
// reached) go from the update state straight to the output stage; emitted steps
// pass through the shaping states, and when notch_div > 1 first through the
// 16-step serial restoring divider. in_ch takes a new beat in the cycle after
// the previous result is loaded into the output register.
// The output register holds a result while out_ch is stalled; the next beat
// is still accepted and worked on, and waits for the register to drain.
// Reset zeroes all encoder state through per-entry valid bits at once (no
// clearing pass) and restores the register defaults. cfg_* writes must come
// only while no beat is in flight.
// ----------------------------------------------------------------------------
module rotary_encoder_accel_shaper import rea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rea_in_if.sink      in_ch,
  rea_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration
  logic       accel_enable_r;
  logic [6:0] accel_factor_r;
  logic [7:0] dead_zone_r;
  logic [7:0] notch_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_enable_r <= 1'b1;
      accel_factor_r <= 7'd5;
      dead_zone_r    <= 8'd1;
      notch_div_r    <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACCEL_ENABLE: accel_enable_r <= cfg_data[0];
        CFG_ACCEL_FACTOR: accel_factor_r <= cfg_data[6:0];
        CFG_DEAD_ZONE:    dead_zone_r    <= cfg_data;
        CFG_NOTCH_DIV:    notch_div_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [ENC_AW-1:0] to_addr(input logic [1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[ENC_AW-1:0];
  endfunction

  // state and handshake
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  // encoder state memory
  slot_t                  mem [NUM_ENCODERS];
  slot_t                  rdata_r;
  logic                   rvld_r;
  logic [NUM_ENCODERS-1:0] vld_r;
  logic                   mem_we;
  slot_t                  mem_wdata;

  // item registers
  logic                     act_r, act_nxt;
  logic [ENC_AW-1:0]        addr_r, addr_nxt;
  logic                     inrange_r, inrange_nxt;
  logic signed [7:0]        delta_r, delta_nxt;
  logic [1:0]               mode_r, mode_nxt;
  logic [STAMP_W-1:0]       now_r, now_nxt;
  logic [SPEED_W-1:0]       speed_r, speed_nxt;
  logic                     neg_r, neg_nxt;
  logic [ACCUM_W-1:0]       quo_r, quo_nxt;
  logic [8:0]               rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [V_W-1:0]    v_r, v_nxt;
  logic [PROD_W-1:0]        p_r, p_nxt;
  logic                     bypass_r, bypass_nxt;
  logic [SPEED_W-1:0]       mult_r, mult_nxt;
  logic signed [STEP_W-1:0] res_r, res_nxt;
  logic signed [STEP_W-1:0] out_step_r, out_step_nxt;

  // update-stage intermediates
  slot_t                     cur;
  logic [STAMP_W-1:0]        dt;
  logic [SPEED_W-1:0]        spd;
  dir_t                      dir;
  logic signed [ACCUM_W-1:0] accum_new;
  logic [ACCUM_W-1:0]        mag;
  logic                      emit;
  // divider intermediates
  logic [8:0]                rem_try;
  logic                      qbit;
  logic [ACCUM_W-1:0]        q_fin;
  logic signed [V_W-1:0]     q_signed;
  // shaping intermediates
  logic [SPEED_W-1:0]        vel;
  logic [PROD_W+15:0]        recip_prod;
  logic [PROD_W-1:0]         q10;
  logic [PROD_W:0]           m_raw;
  logic signed [V_W+SPEED_W:0] full_prod;

  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data.step_out = out_step_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rdata_r <= mem[to_addr(in_ch.data.encoder_index)];
      rvld_r  <= vld_r[to_addr(in_ch.data.encoder_index)];
    end
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_step_nxt  = out_step_r;
    act_nxt       = act_r;
    addr_nxt      = addr_r;
    inrange_nxt   = inrange_r;
    delta_nxt     = delta_r;
    mode_nxt      = mode_r;
    now_nxt       = now_r;
    speed_nxt     = speed_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    v_nxt         = v_r;
    p_nxt         = p_r;
    bypass_nxt    = bypass_r;
    mult_nxt      = mult_r;
    res_nxt       = res_r;
    in_ch.ready   = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = '0;

    cur = rvld_r ? rdata_r : '0;
    dt  = now_r - cur.stamp_ms;
    if (dt < FAST_MS) begin
      spd = (cur.speed < SPEED_MAX) ? cur.speed + 4'd1 : cur.speed;
    end else if (dt > SLOW_MS) begin
      spd = '0;
    end else begin
      spd = (cur.speed != '0) ? cur.speed - 4'd1 : '0;
    end
    dir = (delta_r > 8'sd0) ? DIR_POS : DIR_NEG;
    // direction reversal kills the velocity
    if (cur.prev_dir != DIR_NONE && cur.prev_dir != dir) begin
      spd = '0;
    end
    accum_new = cur.accum + ACCUM_W'(delta_r);
    mag       = accum_new[ACCUM_W-1] ? ACCUM_W'(-accum_new) : ACCUM_W'(accum_new);
    emit      = mag >= ACCUM_W'(dead_zone_r);

    rem_try  = {rem_r[7:0], quo_r[ACCUM_W-1]};
    qbit     = rem_try >= {1'b0, notch_div_r};
    q_fin    = {quo_r[ACCUM_W-2:0], qbit};
    q_signed = neg_r ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});

    vel        = (mode_t'(mode_r) == MODE_LIST) ? (speed_r >> 1) : speed_r;
    recip_prod = (PROD_W+16)'(p_r) * (PROD_W+16)'(RECIP_10);
    q10        = recip_prod[RECIP_SHIFT +: PROD_W];
    m_raw      = (PROD_W+1)'(q10) + (PROD_W+1)'(1);
    full_prod  = v_r * $signed({1'b0, mult_r});

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          act_nxt     = in_ch.data.action;
          addr_nxt    = to_addr(in_ch.data.encoder_index);
          inrange_nxt = 32'(in_ch.data.encoder_index) < NUM_ENCODERS;
          delta_nxt   = in_ch.data.raw_delta;
          mode_nxt    = in_ch.data.shaping_mode;
          now_nxt     = in_ch.data.now_ms;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        res_nxt   = '0;
        state_nxt = S_FIN;
        if (!inrange_r) begin
          state_nxt = S_FIN;
        end else if (act_t'(act_r) == ACT_CLEAR) begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end else if (delta_r != 8'sd0) begin
          mem_we             = 1'b1;
          mem_wdata.accum    = emit ? '0 : accum_new;
          mem_wdata.stamp_ms = now_r;
          mem_wdata.prev_dir = dir;
          mem_wdata.speed    = spd;
          speed_nxt          = spd;
          if (emit) begin
            if (notch_div_r > 8'd1) begin
              quo_nxt   = mag;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              neg_nxt   = accum_new[ACCUM_W-1];
              state_nxt = S_DIV;
            end else begin
              v_nxt     = V_W'(accum_new);
              state_nxt = S_ACC;
            end
          end
        end
      end
      S_DIV: begin
        rem_nxt = qbit ? rem_try - {1'b0, notch_div_r} : rem_try;
        quo_nxt = q_fin;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACCUM_W - 1)) begin
          // a zero quotient keeps one step in the direction of this beat
          if (q_fin == '0) begin
            v_nxt = (delta_r > 8'sd0) ? V_W'(1) : -V_W'(1);
          end else begin
            v_nxt = q_signed;
          end
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        p_nxt      = PROD_W'(vel) * PROD_W'(accel_factor_r);
        bypass_nxt = !accel_enable_r ||
                     (mode_t'(mode_r) == MODE_LIST && speed_r <= LIST_SPEED_MIN);
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        if (bypass_r) begin
          mult_nxt = SPEED_W'(1);
        end else if (m_raw > (PROD_W+1)'(MULT_MAX)) begin
          mult_nxt = MULT_MAX;
        end else begin
          mult_nxt = m_raw[SPEED_W-1:0];
        end
        state_nxt = S_PROD;
      end
      S_PROD: begin
        if (mode_t'(mode_r) == MODE_NAV) begin
          res_nxt = (v_r > V_W'(0)) ? STEP_W'(1) : -STEP_W'(1);
        end else begin
          res_nxt = full_prod[STEP_W-1:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_step_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_step_r <= out_step_nxt;
    act_r      <= act_nxt;
    addr_r     <= addr_nxt;
    inrange_r  <= inrange_nxt;
    delta_r    <= delta_nxt;
    mode_r     <= mode_nxt;
    now_r      <= now_nxt;
    speed_r    <= speed_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    v_r        <= v_nxt;
    p_r        <= p_nxt;
    bypass_r   <= bypass_nxt;
    mult_r     <= mult_nxt;
    res_r      <= res_nxt;
  end

endmodule

>>> sv/rea_checker.sv
// ----------------------------------------------------------------------------
// rea_checker
// Port-level checks on the encoder shaper channels, bound into the shaper module.
// ----------------------------------------------------------------------------
module rea_checker import rea_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [STEP_W-1:0] out_step
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_step))
    else $error("out payload changed while stalled");

  // one beat in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // a result needs at least the read and update cycles after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result shown before state read");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("out valid after reset");

endmodule

bind rotary_encoder_accel_shaper rea_checker u_rea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_step  (out_ch.data.step_out)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotary_encoder_accel_shaper. A directed opening
// hits the field extremes, every mode, the velocity thresholds, clears, bad
// indices, zero deltas and timestamp wrap. Random encoder gestures follow
// under several register settings, extremes included. Each event is scored
// against an in-bench model of velocity, dead zone, detent and shaping.
// ----------------------------------------------------------------------------
module tb;
  import rea_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  rea_in_if  in_ch ();
  rea_out_if out_ch ();

  rotary_encoder_accel_shaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies and per-encoder tracking state
  logic                      cfg_en;
  logic [6:0]                cfg_fac;
  logic [7:0]                cfg_dz;
  logic [7:0]                cfg_det;
  logic signed [ACCUM_W-1:0] enc_acc [NUM_ENCODERS];
  logic [STAMP_W-1:0]        enc_t   [NUM_ENCODERS];
  dir_t                      enc_dir [NUM_ENCODERS];
  logic [SPEED_W-1:0]        enc_vel [NUM_ENCODERS];

  rea_in_t                  event_q [$];
  logic signed [STEP_W-1:0] step_q [$];
  logic [31:0]              tnow [4];

  int  n_events, n_steps, n_nonzero, n_bad, n_settings;
  bit  in_taken;
  int  in_gap, in_calm, out_hold, out_calm;

  function automatic int boost(int v, logic [SPEED_W-1:0] vel);
    int mult;
    if (!cfg_en) return v;
    mult = 1 + (int'(vel) * int'(cfg_fac)) / 10;
    if (mult > int'(MULT_MAX)) mult = int'(MULT_MAX);
    return v * mult;
  endfunction

  function automatic logic signed [STEP_W-1:0] shape_step(rea_in_t ev);
    int          idx, del, acc, mag, v, res;
    logic [31:0] dt;
    dir_t        d;
    idx = ev.encoder_index;
    del = $signed(ev.raw_delta);
    if (idx >= NUM_ENCODERS) return '0;
    if (ev.action == ACT_CLEAR) begin
      enc_acc[idx] = '0;
      enc_t[idx]   = '0;
      enc_dir[idx] = DIR_NONE;
      enc_vel[idx] = '0;
      return '0;
    end
    if (del == 0) return '0;
    dt = ev.now_ms - enc_t[idx];
    if (dt < FAST_MS) begin
      if (enc_vel[idx] < SPEED_MAX) enc_vel[idx] = enc_vel[idx] + 1'b1;
    end else if (dt > SLOW_MS) begin
      enc_vel[idx] = '0;
    end else if (enc_vel[idx] > 0) begin
      enc_vel[idx] = enc_vel[idx] - 1'b1;
    end
    d = (del > 0) ? DIR_POS : DIR_NEG;
    if (enc_dir[idx] != DIR_NONE && enc_dir[idx] != d) enc_vel[idx] = '0;
    enc_dir[idx] = d;
    enc_t[idx]   = ev.now_ms;
    acc = enc_acc[idx] + del;
    mag = (acc < 0) ? -acc : acc;
    if (mag < int'(cfg_dz)) begin
      enc_acc[idx] = acc[ACCUM_W-1:0];
      return '0;
    end
    enc_acc[idx] = '0;
    v = acc;
    if (cfg_det > 1) begin
      v = v / int'(cfg_det);
      if (v == 0) v = (del > 0) ? 1 : -1;
    end
    case (ev.shaping_mode)
      MODE_NAV:              res = (v > 0) ? 1 : -1;
      MODE_EDIT, MODE_ADJUST: res = boost(v, enc_vel[idx]);
      default:               res = (enc_vel[idx] > LIST_SPEED_MIN) ? boost(v, enc_vel[idx] / 2) : v;
    endcase
    return res[STEP_W-1:0];
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 49);
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return 49;
        1:       return 50;
        2:       return 200;
        default: return 201;
      endcase
    end
    if (r < 85) return $urandom_range(50, 200);
    return $urandom_range(201, $urandom_range(201, 70000));
  endfunction

  function automatic void push_ev(act_t a, logic [1:0] idx, logic [7:0] delta,
                                  logic [1:0] mode, logic [31:0] now);
    rea_in_t ev;
    ev.action        = a;
    ev.encoder_index = idx;
    ev.raw_delta     = delta;
    ev.shaping_mode  = mode;
    ev.now_ms        = now;
    event_q.push_back(ev);
  endfunction

  task automatic write_regs(input logic en, input logic [6:0] fac,
                            input logic [7:0] dz, input logic [7:0] det);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACCEL_ENABLE;
    cfg_data  <= {7'd0, en};
    cfg_en = en;
    @(negedge clk);
    cfg_index <= CFG_ACCEL_FACTOR;
    cfg_data  <= {1'b0, fac};
    cfg_fac = fac;
    @(negedge clk);
    cfg_index <= CFG_DEAD_ZONE;
    cfg_data  <= dz;
    cfg_dz = dz;
    @(negedge clk);
    cfg_index <= CFG_NOTCH_DIV;
    cfg_data  <= det;
    cfg_det = det;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // sender holds off until the block has drained every result
  task automatic wait_idle();
    do @(posedge clk);
    while (event_q.size() != 0 || in_ch.valid || step_q.size() != 0);
  endtask

  task automatic gen_events(input int n);
    int         made, kind, len, idx, mag, delta, k;
    logic [1:0] mode;
    bit         neg, fixed_mode;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        push_ev(ACT_CLEAR, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                2'($urandom_range(0, 3)), $urandom);
        made++;
      end else if (kind < 12) begin
        push_ev(act_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), $urandom);
        made++;
      end else if (kind < 16) begin
        idx = $urandom_range(0, 1);
        tnow[idx] += next_dt();
        push_ev(ACT_MOVE, 2'(idx), 8'd0, 2'($urandom_range(0, 3)), tnow[idx]);
        made++;
      end else begin
        // one gesture: a run of turns on a single encoder
        idx        = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
        neg        = ($urandom_range(0, 1) != 0);
        len        = $urandom_range(1, 24);
        mode       = 2'($urandom_range(0, 3));
        fixed_mode = ($urandom_range(0, 3) != 0);
        for (k = 0; k < len && made < n; k++) begin
          if ($urandom_range(0, 19) == 0) neg = !neg;
          kind = $urandom_range(0, 99);
          if (kind < 65) mag = $urandom_range(1, 4);
          else if (kind < 90) mag = $urandom_range(5, 40);
          else mag = $urandom_range(41, 128);
          if (!neg && mag > 127) mag = 127;
          delta = neg ? -mag : mag;
          tnow[idx] += next_dt();
          push_ev(ACT_MOVE, 2'(idx), delta[7:0],
                  fixed_mode ? mode : 2'($urandom_range(0, 3)), tnow[idx]);
          made++;
        end
      end
    end
  endtask

  // input driver: a beat stays up until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (event_q.size() > 0) begin
        in_ch.data  <= event_q.pop_front();
        in_ch.valid <= 1'b1;
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else if ($urandom_range(0, 99) < 2) begin
          in_calm = $urandom_range(30, 150);
          in_gap  = 0;
        end else begin
          in_gap = idle_len();
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (out_calm > 0) begin
      out_calm--;
      out_ch.ready <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 2) out_calm = $urandom_range(30, 150);
      else if ($urandom_range(0, 99) < 20) out_hold = idle_len() + 1;
    end
  end

  always @(posedge clk) begin
    logic signed [STEP_W-1:0] want, got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data.step_out;
        n_steps++;
        if (got != 0) n_nonzero++;
        if (step_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("[%0t] unexpected result beat step_out=%0d", $time, got);
        end else begin
          want = step_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("[%0t] step_out mismatch: expected %0d, got %0d", $time, want, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        step_q.push_back(shape_step(in_ch.data));
        in_taken = 1'b1;
        n_events++;
      end
    end
  end

  initial begin
    int p, i;
    logic [7:0] dz_r, det_r;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ACCEL_ENABLE;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_en  = 1'b1;
    cfg_fac = 7'd5;
    cfg_dz  = 8'd1;
    cfg_det = 8'd1;
    for (i = 0; i < NUM_ENCODERS; i++) begin
      enc_acc[i] = '0;
      enc_t[i]   = '0;
      enc_dir[i] = DIR_NONE;
      enc_vel[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, on the reset defaults
    push_ev(ACT_MOVE, 2'd0, 8'd1, MODE_NAV, 32'd10);
    push_ev(ACT_MOVE, 2'd0, 8'd127, MODE_EDIT, 32'd20);
    push_ev(ACT_MOVE, 2'd0, -8'sd128, MODE_ADJUST, 32'd30);
    push_ev(ACT_MOVE, 2'd0, 8'd0, MODE_LIST, 32'd40);
    push_ev(ACT_MOVE, 2'd2, 8'd5, MODE_EDIT, 32'd50);
    push_ev(ACT_CLEAR, 2'd3, 8'hFF, MODE_NAV, 32'd60);
    push_ev(ACT_MOVE, 2'd3, -8'sd1, MODE_LIST, 32'hFFFF_FFFF);
    // fast burst drives speed into the clamp
    for (i = 0; i < 10; i++) push_ev(ACT_MOVE, 2'd1, 8'd3, MODE_LIST, 32'd20 + 10 * i);
    // threshold spacing: just fast, lower bound, upper bound, just slow
    push_ev(ACT_MOVE, 2'd1, 8'd2, MODE_ADJUST, 32'd159);
    push_ev(ACT_MOVE, 2'd1, 8'd2, MODE_ADJUST, 32'd209);
    push_ev(ACT_MOVE, 2'd1, 8'd2, MODE_ADJUST, 32'd409);
    push_ev(ACT_MOVE, 2'd1, 8'd2, MODE_ADJUST, 32'd610);
    push_ev(ACT_CLEAR, 2'd1, 8'd0, MODE_EDIT, 32'd612);
    push_ev(ACT_MOVE, 2'd1, -8'sd7, MODE_EDIT, 32'd615);
    // timestamp wrap
    push_ev(ACT_MOVE, 2'd0, -8'sd5, MODE_ADJUST, 32'hFFFF_FFF0);
    push_ev(ACT_MOVE, 2'd0, -8'sd5, MODE_ADJUST, 32'h0000_0010);
    wait_idle();

    // park a partial count on each encoder, then let them cancel to zero with no dead zone
    write_regs(1'b1, 7'd5, 8'd10, 8'd1);
    push_ev(ACT_MOVE, 2'd0, 8'd4, MODE_NAV, 32'h0000_0020);
    push_ev(ACT_MOVE, 2'd1, -8'sd2, MODE_EDIT, 32'd700);
    wait_idle();

    for (i = 0; i < 4; i++) tnow[i] = $urandom;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: write_regs(1'b0, 7'd0, 8'd0, 8'd0);
        1: write_regs(1'b1, 7'd127, 8'd255, 8'd255);
        2: write_regs(1'b1, 7'd100, 8'd2, 8'd2);
        3: write_regs(1'b1, 7'd10, 8'd1, 8'd1);
        4: write_regs(1'b1, 7'd127, 8'd0, 8'd3);
        default: begin
          dz_r  = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 6)) :
                                                 8'($urandom_range(0, 255));
          det_r = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 4)) :
                                                 8'($urandom_range(0, 255));
          write_regs($urandom_range(0, 3) != 0, 7'($urandom_range(0, 127)), dz_r, det_r);
        end
      endcase
      if (p == 0) begin
        push_ev(ACT_MOVE, 2'd0, -8'sd4, MODE_NAV, 32'h0000_0030);
        push_ev(ACT_MOVE, 2'd1, 8'd2, MODE_EDIT, 32'd710);
      end
      for (i = 0; i < 4; i++)
        if ($urandom_range(0, 3) == 0) tnow[i] = 32'hFFFF_FFFF - $urandom_range(0, 4000);
      gen_events(200);
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (step_q.size() != 0) begin
      n_bad++;
      $display("%0d expected results never arrived", step_q.size());
    end
    $display("summary: %0d events under %0d register settings, %0d results checked",
             n_events, n_settings, n_steps);
    $display("summary: %0d nonzero steps, %0d mismatches", n_nonzero, n_bad);
    if (n_bad == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
sv/rea_pkg.sv
sv/rea_in_if.sv
sv/rea_out_if.sv
sv/rotary_encoder_accel_shaper.sv
sv/rea_checker.sv
sim/tb.sv
